// File: rtl/qalu_pkg.sv
// Shared types, widths and saturation helper for the quaternion ALU.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

    localparam int WordBits = 16;                       // component width
    localparam int FracBits = 13;                       // fraction bits (Q2.13)
    localparam int ProdBits = 2 * WordBits;             // one exact product
    localparam int SumBits  = 2 * WordBits + 2;         // sum of four products, signed
    localparam int SqBits   = 2 * WordBits + 1;         // sum of four squares
    localparam int RootBits = WordBits + 1;             // rounded root
    localparam int DenBits  = SqBits - FracBits;        // divisor (root or squared norm)
    localparam int NumBits  = WordBits + FracBits + 1;  // scaled dividend
    localparam int InDataBits  = 8 * WordBits;
    localparam int OutDataBits = 4 * WordBits;

    localparam logic signed [SumBits-1:0] SatHi = SumBits'((2 ** (WordBits - 1)) - 1);
    localparam logic signed [SumBits-1:0] SatLo = -SatHi - SumBits'(1);

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_CONJ = 3'd1,
        OP_NORM = 3'd2,
        OP_NRM  = 3'd3,
        OP_INV  = 3'd4
    } op_t;

    typedef struct packed {
        logic [WordBits-1:0] val;
        logic                ov;
    } sat_t;

    // Per-item sideband carried alongside the long arithmetic pipes.
    typedef struct packed {
        op_t                      op;
        logic [3:0][WordBits-1:0] r;    // result for ops that need no divide
        logic                     ov;
        logic                     zn;
        logic [3:0]               neg;  // sign of each divide lane's result
        logic [3:0][WordBits-1:0] a;
    } side_t;

    function automatic sat_t sat_word(input logic signed [SumBits-1:0] v);
        sat_t res;
        res.val = v[WordBits-1:0];
        res.ov  = 1'b0;
        if (v > SatHi)
        begin
            res.val = SatHi[WordBits-1:0];
            res.ov  = 1'b1;
        end
        else if (v < SatLo)
        begin
            res.val = SatLo[WordBits-1:0];
            res.ov  = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/qalu_front.sv
// Front end: all products and squares, then Hamilton sums, conjugate and sum of squares.
// Depends on qalu_pkg. Two register stages.
`timescale 1ns / 1ps
`default_nettype none

module qalu_front
    import qalu_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  op_t                      op,
    input  logic [3:0][WordBits-1:0] a,
    input  logic [3:0][WordBits-1:0] b,
    output side_t                    side,
    output logic [SqBits-1:0]        sum_sq
);

    logic signed [ProdBits-1:0] prod_reg [4][4];
    logic signed [ProdBits-1:0] sq_reg   [4];
    logic [3:0][WordBits-1:0]   a1_reg;
    op_t                        op1_reg;

    side_t              side_reg, side_next;
    logic [SqBits-1:0]  sum_sq_reg, sum_sq_next;

    localparam logic signed [SumBits-1:0] Half = SumBits'(2 ** (FracBits - 1));

    // Stage 1: sixteen cross products and four squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= $signed(a[i]) * $signed(b[j]);
                end
                sq_reg[i] <= $signed(a[i]) * $signed(a[i]);
            end
            a1_reg  <= a;
            op1_reg <= op;
        end
    end

    // Stage 2: sums, round half up, saturate
    always_comb
    begin
        logic signed [SumBits-1:0] s [4];
        sat_t                      m [4];
        sat_t                      c [4];
        s[0] = SumBits'(prod_reg[0][0]) - SumBits'(prod_reg[1][1])
             - SumBits'(prod_reg[2][2]) - SumBits'(prod_reg[3][3]);
        s[1] = SumBits'(prod_reg[0][1]) + SumBits'(prod_reg[1][0])
             + SumBits'(prod_reg[2][3]) - SumBits'(prod_reg[3][2]);
        s[2] = SumBits'(prod_reg[0][2]) - SumBits'(prod_reg[1][3])
             + SumBits'(prod_reg[2][0]) + SumBits'(prod_reg[3][1]);
        s[3] = SumBits'(prod_reg[0][3]) + SumBits'(prod_reg[1][2])
             - SumBits'(prod_reg[2][1]) + SumBits'(prod_reg[3][0]);
        for (int i = 0; i < 4; i++)
        begin
            m[i] = sat_word((s[i] + Half) >>> FracBits);
            if (i == 0)
                c[i] = sat_word(SumBits'($signed(a1_reg[i])));
            else
                c[i] = sat_word(-SumBits'($signed(a1_reg[i])));
        end

        side_next     = '0;
        side_next.op  = op1_reg;
        side_next.a   = a1_reg;
        case (op1_reg)
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side_next.r[i] = m[i].val;
                end
                side_next.ov = m[0].ov | m[1].ov | m[2].ov | m[3].ov;
            end
            OP_CONJ:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side_next.r[i] = c[i].val;
                end
                side_next.ov = c[0].ov | c[1].ov | c[2].ov | c[3].ov;
            end
            default:
            begin
                side_next.ov = 1'b0;
            end
        endcase

        sum_sq_next = SqBits'($unsigned(sq_reg[0])) + SqBits'($unsigned(sq_reg[1]))
                    + SqBits'($unsigned(sq_reg[2])) + SqBits'($unsigned(sq_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= side_next;
            sum_sq_reg <= sum_sq_next;
        end
    end

    assign side   = side_reg;
    assign sum_sq = sum_sq_reg;

endmodule

`default_nettype wire

// File: rtl/qalu_sqrt.sv
// Pipelined digit-by-digit square root, one result bit per stage, then round half up.
// Depends on qalu_pkg. A rounding register follows the digit stages.
`timescale 1ns / 1ps
`default_nettype none

module qalu_sqrt
    import qalu_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SqBits-1:0]   sum_sq,
    output logic [RootBits-1:0] root,
    output logic [SqBits-1:0]   sum_sq_out
);

    localparam int WorkBits = SqBits + 1;

    logic [WorkBits-1:0] rem_reg [RootBits];
    logic [WorkBits-1:0] res_reg [RootBits];
    logic [SqBits-1:0]   s_reg   [RootBits];
    logic [RootBits-1:0] root_reg;
    logic [SqBits-1:0]   s_out_reg;

    for (genvar j = 0; j < RootBits; j++)
    begin : g_step
        localparam logic [WorkBits-1:0] Bit = WorkBits'(1) << (2 * (RootBits - 1 - j));
        logic [WorkBits-1:0] rem_i, res_i, trial;
        logic [SqBits-1:0]   s_i;
        logic                take;

        if (j == 0)
        begin : g_first
            assign rem_i = WorkBits'(sum_sq);
            assign res_i = '0;
            assign s_i   = sum_sq;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[j-1];
            assign res_i = res_reg[j-1];
            assign s_i   = s_reg[j-1];
        end

        assign trial = res_i + Bit;
        assign take  = rem_i >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? rem_i - trial : rem_i;
                res_reg[j] <= take ? (res_i >> 1) + Bit : res_i >> 1;
                s_reg[j]   <= s_i;
            end
        end
    end

    // Round to nearest: bump the floor root when remainder exceeds it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg  <= res_reg[RootBits-1][RootBits-1:0]
                       + RootBits'(rem_reg[RootBits-1] > res_reg[RootBits-1]);
            s_out_reg <= s_reg[RootBits-1];
        end
    end

    assign root       = root_reg;
    assign sum_sq_out = s_out_reg;

endmodule

`default_nettype wire

// File: rtl/qalu_div.sv
// One divider lane: pipelined restoring division, one quotient bit per stage.
// Depends on qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_div
    import qalu_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [NumBits-1:0] num,
    input  logic [DenBits:0]   dvs,
    output logic [NumBits-1:0] quot
);

    localparam int DvsBits = DenBits + 1;

    logic [DvsBits-1:0] rem_reg [NumBits];
    logic [NumBits-1:0] q_reg   [NumBits];
    logic [NumBits-1:0] n_reg   [NumBits];
    logic [DvsBits-1:0] d_reg   [NumBits];

    for (genvar k = 0; k < NumBits; k++)
    begin : g_step
        logic [DvsBits-1:0] rem_i, d_i;
        logic [NumBits-1:0] q_i, n_i;
        logic [DvsBits:0]   sh;
        logic               take;

        if (k == 0)
        begin : g_first
            assign rem_i = '0;
            assign q_i   = '0;
            assign n_i   = num;
            assign d_i   = dvs;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[k-1];
            assign q_i   = q_reg[k-1];
            assign n_i   = n_reg[k-1];
            assign d_i   = d_reg[k-1];
        end

        assign sh   = {rem_i, n_i[NumBits-1-k]};
        assign take = sh >= {1'b0, d_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? DvsBits'(sh - {1'b0, d_i}) : DvsBits'(sh);
                q_reg[k]   <= {q_i[NumBits-2:0], take};
                n_reg[k]   <= n_i;
                d_reg[k]   <= d_i;
            end
        end
    end

    assign quot = q_reg[NumBits-1];

endmodule

`default_nettype wire

// File: rtl/quaternion_alu_top.sv
// Top level of the fixed-point quaternion ALU: front end, root pipe, four divider lanes, merge.
// Depends on qalu_pkg, qalu_front, qalu_sqrt and qalu_div.
//
//  channel  | dir | tdata                          | tuser
//  ---------+-----+--------------------------------+---------------------------
//  s_axis   | in  | a_w a_x a_y a_z b_w b_x b_y b_z| req_type
//  m_axis   | out | r_w r_x r_y r_z                | zero_norm, overflow
//
// One transaction is accepted every cycle unless the output stalls; every opcode goes through
// the same 52-stage pipe (2 front, 18 root, 1 divisor prep, 30 divide, 1 output register).
// The length is set by the bit-per-stage divider lanes and root pipe. Reset clears only the
// valid bits. A stalled output freezes the whole pipe; s_axis_tready drops only while a result
// waits with m_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu_top
    import qalu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [InDataBits-1:0]  s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [2:0]             s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OutDataBits-1:0] m_axis_tdata,   // r_w, r_x, r_y, r_z
    output logic [1:0]             m_axis_tuser    // zero_norm, overflow
);

    localparam int SqrtLat   = RootBits + 1;
    localparam int DivLat    = NumBits;
    localparam int PipeDepth = 2 + SqrtLat + 1 + DivLat + 1;

    logic [PipeDepth-1:0] vld_reg;
    logic                 en;

    // Whole pipe advances unless the output register holds an untaken result
    assign en            = !vld_reg[PipeDepth-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PipeDepth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PipeDepth-2:0], s_axis_tvalid};
        end
    end

    // Front end: products, Hamilton sums, conjugate, sum of squares
    side_t             front_side;
    logic [SqBits-1:0] front_s;

    qalu_front u_front (
        .clk    (clk),
        .en     (en),
        .op     (op_t'(s_axis_tuser)),
        .a      (s_axis_tdata[OutDataBits-1:0]),
        .b      (s_axis_tdata[InDataBits-1:OutDataBits]),
        .side   (front_side),
        .sum_sq (front_s)
    );

    // Rounded norm
    logic [RootBits-1:0] sq_root;
    logic [SqBits-1:0]   sq_s;

    qalu_sqrt u_sqrt (
        .clk        (clk),
        .en         (en),
        .sum_sq     (front_s),
        .root       (sq_root),
        .sum_sq_out (sq_s)
    );

    // Hold sideband in step with the root pipe
    side_t side1_reg [SqrtLat];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= front_side;
            for (int k = 1; k < SqrtLat; k++)
            begin
                side1_reg[k] <= side1_reg[k-1];
            end
        end
    end

    // Divisor prep: pick root (normalize) or squared norm (inverse), build dividends
    side_t                   side_p_reg, side_p_next;
    logic [3:0][NumBits-1:0] num_reg, num_next;
    logic [DenBits:0]        dvs_reg, dvs_next;

    always_comb
    begin
        logic [DenBits-1:0]  n2;
        logic [DenBits-1:0]  den;
        logic [WordBits-1:0] mag;
        sat_t                nsat;
        side_t               si;
        si   = side1_reg[SqrtLat-1];
        n2   = DenBits'(sq_s >> FracBits) + DenBits'(sq_s[FracBits-1]);
        den  = (si.op == OP_NRM) ? DenBits'(sq_root) : n2;
        nsat = sat_word(SumBits'(sq_root));
        side_p_next    = si;
        side_p_next.zn = (den == '0);
        if (si.op == OP_NORM)
        begin
            side_p_next.r    = '0;
            side_p_next.r[0] = nsat.val;
            side_p_next.ov   = nsat.ov;
        end
        for (int i = 0; i < 4; i++)
        begin
            mag = $signed(si.a[i]) < 0 ? WordBits'(-si.a[i]) : si.a[i];
            if (si.op == OP_INV && i != 0)
                side_p_next.neg[i] = $signed(si.a[i]) > 0;
            else
                side_p_next.neg[i] = $signed(si.a[i]) < 0;
            num_next[i] = (NumBits'(mag) << (FracBits + 1)) + NumBits'(den);
        end
        dvs_next = {den, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_p_reg <= side_p_next;
            num_reg    <= num_next;
            dvs_reg    <= dvs_next;
        end
    end

    // Four divider lanes, one per component
    logic [3:0][NumBits-1:0] quot;

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        qalu_div u_div (
            .clk  (clk),
            .en   (en),
            .num  (num_reg[i]),
            .dvs  (dvs_reg),
            .quot (quot[i])
        );
    end

    side_t side2_reg [DivLat];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg[0] <= side_p_reg;
            for (int k = 1; k < DivLat; k++)
            begin
                side2_reg[k] <= side2_reg[k-1];
            end
        end
    end

    // Merge: apply signs, saturate, fold lane flags into one result
    logic [OutDataBits-1:0] out_data_reg, out_data_next;
    logic [1:0]             out_user_reg, out_user_next;

    always_comb
    begin
        side_t                     sf;
        sat_t                      q [4];
        logic signed [SumBits-1:0] v;
        logic                      ov;
        sf = side2_reg[DivLat-1];
        ov = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            v = $signed(SumBits'(quot[i]));
            if (sf.neg[i])
                v = -v;
            q[i] = sat_word(v);
            ov   = ov | q[i].ov;
        end
        case (sf.op)
            OP_NRM, OP_INV:
            begin
                if (sf.zn)
                begin
                    out_data_next = '0;
                    out_user_next = 2'b01;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        out_data_next[i*WordBits +: WordBits] = q[i].val;
                    end
                    out_user_next = {ov, 1'b0};
                end
            end
            default:
            begin
                out_data_next = sf.r;
                out_user_next = {sf.ov, 1'b0};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

`default_nettype wire

// File: rtl/qalu_checker.sv
// Port-level checker for quaternion_alu_top and the bind that attaches it.
// Depends on qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_checker
    import qalu_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [InDataBits-1:0]  s_axis_tdata,
    input wire logic [2:0]             s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OutDataBits-1:0] m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Input stalls only behind a waiting result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // Zero divisor drops all components
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero_norm with nonzero components");

    // Zero divisor never reports saturation
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("zero_norm and overflow together");

endmodule

bind quaternion_alu_top qalu_checker u_qalu_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for quaternion_alu_top: directed table, then random traffic.
// Depends on qalu_pkg and the RTL of quaternion_alu_top; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import qalu_pkg::*;

    localparam int HoldLimit   = 4000;   // idle cycles before the watchdog trips
    localparam int RandomCount = 1900;
    localparam int Latency     = 52;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zn;
        logic               ov;
    } quat_res_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        bit                 typed;   // expected result given in the row
        quat_res_t          res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [InDataBits-1:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OutDataBits-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    quat_res_t result_queue[$];
    int errors;
    int sent;
    int received;
    int idle_cycles;
    bit stim_done;
    bit long_hold;   // receiver holds off while the sender keeps offering

    quaternion_alu_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Saturate a wide value into one component, flagging overflow.
    function automatic logic signed [15:0] clamp16(input longint v, inout bit ov);
        if (v > 32767)
        begin
            ov = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            ov = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // c * 2^13 / den, nearest with ties away from zero
    function automatic longint scaled_quot(input longint c, input longint den);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = ((mag <<< FracBits) * 2 + den) / (2 * den);
        return (c < 0) ? -q : q;
    endfunction

    // Floor of the rounded-half-up 2F -> F fraction rescale; sums fit in 64 bits here.
    function automatic longint round_fix(input longint s);
        return (s + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    endfunction

    function automatic quat_res_t quat_compute(input logic [2:0] op,
                                               input logic signed [15:0] a [4],
                                               input logic signed [15:0] b [4]);
        quat_res_t res;
        longint av [4];
        longint bv [4];
        longint r [4];
        longint sq;
        longint root;
        longint n2;
        bit ov;
        ov = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            av[i] = a[i];
            bv[i] = b[i];
            r[i] = 0;
        end
        res.zn = 1'b0;
        sq = av[0]*av[0] + av[1]*av[1] + av[2]*av[2] + av[3]*av[3];
        // floor root, one bit at a time from the top
        root = 0;
        for (int k = 16; k >= 0; k--)
        begin
            if ((root + (64'sd1 <<< k)) * (root + (64'sd1 <<< k)) <= sq)
                root = root + (64'sd1 <<< k);
        end
        if (sq - root * root > root)
            root++;
        case (op)
            OP_MUL:
            begin
                r[0] = round_fix(av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2] - av[3]*bv[3]);
                r[1] = round_fix(av[0]*bv[1] + av[1]*bv[0] + av[2]*bv[3] - av[3]*bv[2]);
                r[2] = round_fix(av[0]*bv[2] - av[1]*bv[3] + av[2]*bv[0] + av[3]*bv[1]);
                r[3] = round_fix(av[0]*bv[3] + av[1]*bv[2] - av[2]*bv[1] + av[3]*bv[0]);
            end
            OP_CONJ:
            begin
                r[0] = av[0];
                r[1] = -av[1];
                r[2] = -av[2];
                r[3] = -av[3];
            end
            OP_NORM:
                r[0] = root;
            OP_NRM:
            begin
                if (root == 0)
                    res.zn = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        r[i] = scaled_quot(av[i], root);
            end
            OP_INV:
            begin
                n2 = (sq >>> FracBits) + ((sq >>> (FracBits - 1)) & 1);
                if (n2 == 0)
                    res.zn = 1'b1;
                else
                begin
                    r[0] = scaled_quot(av[0], n2);
                    for (int i = 1; i < 4; i++)
                        r[i] = scaled_quot(-av[i], n2);
                end
            end
            default: ;
        endcase
        res.w = clamp16(r[0], ov);
        res.x = clamp16(r[1], ov);
        res.y = clamp16(r[2], ov);
        res.z = clamp16(r[3], ov);
        res.ov = ov;
        return res;
    endfunction

    function automatic stim_row_t make_row(input logic [2:0] op,
                                           input logic [63:0] a, input logic [63:0] b);
        stim_row_t row;
        row.op = op;
        for (int i = 0; i < 4; i++)
        begin
            row.a[i] = a[63 - 16*i -: 16];
            row.b[i] = b[63 - 16*i -: 16];
        end
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t row, input quat_res_t res);
        row.typed = 1'b1;
        row.res = res;
        return row;
    endfunction

    // Random component: mostly moderate magnitudes, sometimes extremes or tiny values.
    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $urandom_range(0, 15) - 8;
            3, 4: return $urandom;
            default: return $urandom_range(0, 16384) - 8192;
        endcase
    endfunction

    // Present one transaction and hold it until it is accepted; drop valid only for a gap.
    task automatic send_item(input stim_row_t row);
        int gap;
        gap = long_hold ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {row.b[3], row.b[2], row.b[1], row.b[0],
                          row.a[3], row.a[2], row.a[1], row.a[0]};
        if (row.typed)
            result_queue.push_back(row.res);
        else
            result_queue.push_back(quat_compute(row.op, row.a, row.b));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // Sender: directed table, then random traffic.
    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        errors = 0;
        sent = 0;
        stim_done = 1'b0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        // identity times identity, extremes, each opcode, zero norm, tiny squared norm, unused opcodes
        rows.push_back(typed_row(make_row(OP_MUL, 64'h2000_0000_0000_0000,
                       64'h2000_0000_0000_0000), '{16'sh2000, 0, 0, 0, 0, 0}));
        rows.push_back(make_row(OP_MUL, 64'h7fff_7fff_7fff_7fff, 64'h7fff_8000_7fff_8000));
        rows.push_back(make_row(OP_MUL, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000));
        rows.push_back(make_row(OP_MUL, 64'h1234_edcb_0fff_f001, 64'h2000_0001_ffff_4000));
        rows.push_back(typed_row(make_row(OP_CONJ, 64'h8000_8000_0001_7fff, 64'h0),
                       '{16'sh8000, 16'sh7fff, 16'shffff, 16'sh8001, 0, 1}));
        rows.push_back(make_row(OP_CONJ, 64'h1234_5678_9abc_def0, 64'hffff_ffff_ffff_ffff));
        rows.push_back(make_row(OP_NORM, 64'h7fff_7fff_7fff_7fff, 64'h0));
        rows.push_back(make_row(OP_NORM, 64'h8000_8000_8000_8000, 64'h0));
        rows.push_back(make_row(OP_NORM, 64'h0003_0004_0000_0000, 64'h0));
        rows.push_back(typed_row(make_row(OP_NRM, 64'h0, 64'h1234_1234_1234_1234),
                       '{0, 0, 0, 0, 1, 0}));
        rows.push_back(make_row(OP_NRM, 64'h0001_0000_0000_0000, 64'h0));
        rows.push_back(make_row(OP_NRM, 64'h8000_8000_8000_8000, 64'h0));
        rows.push_back(make_row(OP_NRM, 64'h2000_ffff_0002_f000, 64'h0));
        rows.push_back(typed_row(make_row(OP_INV, 64'h0, 64'h0), '{0, 0, 0, 0, 1, 0}));
        rows.push_back(typed_row(make_row(OP_INV, 64'h0001_0001_0001_0001, 64'h0),
                       '{0, 0, 0, 0, 1, 0}));
        rows.push_back(make_row(OP_INV, 64'h0040_0000_0000_0000, 64'h0));
        rows.push_back(make_row(OP_INV, 64'h8000_8000_8000_8000, 64'h0));
        rows.push_back(make_row(OP_INV, 64'h2000_0000_0000_0000, 64'h0));
        rows.push_back(make_row(OP_INV, 64'hf000_0800_ff00_0010, 64'h0));
        rows.push_back(typed_row(make_row(3'd5, 64'h7fff_8000_1234_5678, 64'hffff_ffff_ffff_ffff),
                       '{0, 0, 0, 0, 0, 0}));
        rows.push_back(typed_row(make_row(3'd6, 64'h8000_8000_8000_8000, 64'h0),
                       '{0, 0, 0, 0, 0, 0}));
        rows.push_back(typed_row(make_row(3'd7, 64'h1111_2222_3333_4444, 64'h0),
                       '{0, 0, 0, 0, 0, 0}));
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i]);
        for (int n = 0; n < RandomCount; n++)
        begin
            row.typed = 1'b0;
            row.res = '0;
            row.op = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            for (int i = 0; i < 4; i++)
            begin
                row.a[i] = rand_comp();
                row.b[i] = rand_comp();
            end
            // long receiver hold-off partway through: keep offering back to back
            if (n == 400)
                long_hold = 1'b1;
            if (n == 600)
                long_hold = 1'b0;
            send_item(row);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off so the pipe fills and blocks input.
    initial
    begin
        int stall;
        bit held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (long_hold && !held)
            begin
                m_axis_tready <= 1'b0;
                repeat (150)
                    @(posedge clk);
                held = 1'b1;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Compare each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        quat_res_t want;
        quat_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[63:48], m_axis_tuser[0], m_axis_tuser[1]};
            received++;
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d zn=%b ov=%b",
                             $realtime, want.w, want.x, want.y, want.z, want.zn, want.ov);
                    $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d zn=%b ov=%b",
                             $realtime, got.w, got.x, got.y, got.z, got.zn, got.ov);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > HoldLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Drain: wait for every expectation, then report the totals.
    initial
    begin
        received = 0;
        idle_cycles = 0;
        wait (stim_done);
        wait (result_queue.size() == 0);
        repeat (Latency + 20)
            @(posedge clk);
        $display("Sent %0d transactions (directed table and random mix of all opcodes),",
                 sent);
        $display("received %0d results with %0d mismatches.", received, errors);
        if (errors == 0 && result_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
